// ----- sv/sfs_pkg.sv -----
// Package for the segment allocator: shared types, status codes and state encoding.
// Used by every module of the allocator; depends on nothing.
`default_nettype none
package sfs_pkg;
    localparam int unsigned MAX_SEGMENTS_DEF = 64;
    localparam int unsigned ADDR_BITS_DEF    = 16;
    localparam int unsigned FIELD_W          = 16;
    localparam logic [15:0] POOL_RESET       = 16'd1000;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_FULL    = 3'd2,
        ST_BADFREE = 3'd3,
        ST_ZERO    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FIT_BEST  = 2'd0,
        FIT_FIRST = 2'd1,
        FIT_NEXT  = 2'd2,
        FIT_WORST = 2'd3
    } t_fit;

    localparam logic CFG_FIT  = 1'b0;
    localparam logic CFG_POOL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FIN_RD,
        S_FIN,
        S_FREE_NX,
        S_FREE_PV,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// ----- sv/segment_allocator_fit_strategies_core.sv -----
// Segment allocator: address-ordered table of segments with first, best,
// next and worst fit, split on allocate and merge on free.
//
// Channels: request in (i_req_type, i_req_size, i_block_offset) with
// i_valid/o_ready; result out (o_status, o_result_offset, o_result_size)
// with o_valid/i_ready; configuration write with i_cfg_valid/o_cfg_ready,
// i_cfg_index (0 fit strategy, 1 pool size) and i_cfg_data.
// One request at a time. A request walks the table through one memory
// read port, one entry a cycle in the scan over the N segments, then a
// shift pass that reads and then writes each moved entry for a split
// or merge. An allocate that splits scans and then shifts once; a free
// that merges with both neighbors scans and then shifts twice.
// A zero-size request goes straight to the done state without a scan.
// The result sits in an output register; while the receiver stalls the
// block holds it and takes no new request.
// Reset gives fit strategy first fit and one free segment of 1000 units;
// writing the pool size reinitializes the table.
`default_nettype none
module segment_allocator_fit_strategies_core
    import sfs_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int unsigned ADDR_BITS    = ADDR_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_req_type,
    input  wire logic [FIELD_W-1:0]  i_req_size,
    input  wire logic [FIELD_W-1:0]  i_block_offset,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [2:0]               o_status,
    output logic [FIELD_W-1:0]       o_result_offset,
    output logic [FIELD_W-1:0]       o_result_size,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_index,
    input  wire logic [FIELD_W-1:0]  i_cfg_data
);
    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = IW + 1;
    localparam int unsigned AW = ADDR_BITS;
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

    t_state        r_st, n_st;
    logic [1:0]    r_fit;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_nfp, n_nfp;
    logic          r_type;
    logic [AW-1:0] r_size, r_off;
    logic [CW-1:0] r_i, n_i;          // scan index
    logic [CW-1:0] r_steps, n_steps;  // entries visited
    logic [CW-1:0] r_pick, n_pick;
    logic          r_found, n_found;
    logic [AW-1:0] r_plen, n_plen, r_pstart, n_pstart;
    logic          r_pused, n_pused;
    logic [CW-1:0] r_j, n_j;          // shift cursor
    logic          r_open, n_open;    // shift direction: open or remove
    logic [CW-1:0] r_lo, n_lo;        // shift bound
    logic [2:0]    r_phase, n_phase;
    logic [2:0]    r_ost, n_ost;
    logic [AW-1:0] r_ooff, n_ooff, r_olen, n_olen;
    logic          r_ov, n_ov;
    logic [AW-1:0] r_acc, n_acc;      // merged length
    logic [AW-1:0] r_ent_start, n_ent_start;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [AW-1:0] wstart, wlen, rstart, rlen;
    logic          wused, rused;

    sfs_table #(.DEPTH(MAX_SEGMENTS), .AW(AW), .IW(IW)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wstart(wstart),
        .i_wlen(wlen), .i_wused(wused), .i_raddr(raddr),
        .o_rstart(rstart), .o_rlen(rlen), .o_rused(rused)
    );

    wire cfg_fire = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = (r_st == S_IDLE);
    assign o_ready     = (r_st == S_IDLE) && !r_ov && !i_cfg_valid;
    assign o_valid     = r_ov;
    assign o_status        = r_ost;
    assign o_result_offset = FIELD_W'(r_ooff);
    assign o_result_size   = FIELD_W'(r_olen);

    // phases of post-scan work
    localparam logic [2:0] PH_SPLIT = 3'd0, PH_NX = 3'd1, PH_PV = 3'd2, PH_END = 3'd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_fit <= FIT_FIRST; r_cnt <= CW'(1); r_nfp <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_nfp <= n_nfp; r_ov <= n_ov;
            if (cfg_fire && i_cfg_index == CFG_FIT) r_fit <= i_cfg_data[1:0];
        end
        r_i <= n_i; r_steps <= n_steps; r_pick <= n_pick; r_found <= n_found;
        r_plen <= n_plen; r_pstart <= n_pstart; r_pused <= n_pused;
        r_j <= n_j; r_open <= n_open; r_lo <= n_lo; r_phase <= n_phase;
        r_ost <= n_ost; r_ooff <= n_ooff; r_olen <= n_olen; r_acc <= n_acc;
        r_ent_start <= n_ent_start;
        if (o_ready && i_valid) begin
            r_type <= i_req_type;
            r_size <= AW'(i_req_size);
            r_off  <= AW'(i_block_offset);
        end
    end

    logic [CW-1:0] ip1;
    logic          hit;
    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_nfp = r_nfp; n_ov = r_ov;
        n_i = r_i; n_steps = r_steps; n_pick = r_pick; n_found = r_found;
        n_plen = r_plen; n_pstart = r_pstart; n_pused = r_pused;
        n_j = r_j; n_open = r_open; n_lo = r_lo; n_phase = r_phase;
        n_ost = r_ost; n_ooff = r_ooff; n_olen = r_olen; n_acc = r_acc;
        n_ent_start = r_ent_start;
        we = 1'b0; waddr = '0; wstart = '0; wlen = '0; wused = 1'b0;
        raddr = r_i[IW-1:0];
        ip1 = r_i + CW'(1);
        hit = 1'b0;
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (cfg_fire && i_cfg_index == CFG_POOL) begin
                    we = 1'b1; waddr = '0; wstart = '0;
                    wlen = AW'(i_cfg_data); wused = 1'b0;
                    n_cnt = CW'(1); n_nfp = '0;
                end else if (o_ready && i_valid) begin
                    n_found = 1'b0; n_steps = '0; n_phase = PH_END;
                    if (i_req_type == 1'b0 && i_req_size == '0) begin
                        n_ost = ST_ZERO; n_st = S_DONE;
                    end else begin
                        n_i = (r_fit == FIT_NEXT && i_req_type == 1'b0 &&
                               CW'(r_nfp) < r_cnt) ? CW'(r_nfp) : '0;
                        n_st = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                raddr = r_i[IW-1:0];
                n_st = S_SCAN;
            end
            S_SCAN: begin
                // rstart/rlen/rused belong to entry r_i
                if (r_type) begin
                    hit = (rstart == r_off);
                end else begin
                    hit = !rused && rlen >= r_size;
                end
                if (hit && (r_type || !r_found || r_fit == FIT_FIRST ||
                            r_fit == FIT_NEXT ||
                            (r_fit == FIT_BEST && rlen < r_plen) ||
                            (r_fit == FIT_WORST && rlen > r_plen))) begin
                    if (!(r_found && (r_type || r_fit == FIT_FIRST || r_fit == FIT_NEXT))) begin
                        n_found = 1'b1; n_pick = r_i; n_plen = rlen;
                        n_pstart = rstart; n_pused = rused;
                    end
                end
                n_steps = r_steps + CW'(1);
                if ((hit && (r_type || r_fit == FIT_FIRST || r_fit == FIT_NEXT)) ||
                    n_steps == r_cnt) begin
                    n_st = S_DECIDE;
                end else begin
                    n_i = (ip1 >= r_cnt) ? '0 : ip1;
                    raddr = n_i[IW-1:0];
                end
            end
            S_DECIDE: begin
                if (!r_found) begin
                    n_ost = r_type ? ST_BADFREE : ST_NOFIT; n_st = S_DONE;
                end else if (r_type) begin
                    if (!r_pused) begin
                        n_ost = ST_BADFREE; n_st = S_DONE;
                    end else begin
                        we = 1'b1; waddr = r_pick[IW-1:0]; wstart = r_pstart;
                        wlen = r_plen; wused = 1'b0;
                        n_acc = r_plen; n_ent_start = r_pstart; n_ost = ST_OK;
                        n_i = r_pick + CW'(1);
                        raddr = n_i[IW-1:0];
                        n_st = S_FREE_NX;
                    end
                end else if (r_plen > r_size) begin
                    if (r_cnt >= MAXC) begin
                        n_ost = ST_FULL; n_st = S_DONE;
                    end else begin
                        // shift entries pick+1..cnt-1 up by one, top first
                        n_open = 1'b1; n_lo = r_pick + CW'(1);
                        n_j = r_cnt; n_phase = PH_SPLIT;
                        n_st = S_SHIFT_RD;
                    end
                end else begin
                    we = 1'b1; waddr = r_pick[IW-1:0]; wstart = r_pstart;
                    wlen = r_plen; wused = 1'b1;
                    n_ost = ST_OK; n_ooff = r_pstart; n_olen = r_plen;
                    n_nfp = (r_pick + CW'(1) < r_cnt) ? IW'(r_pick + CW'(1)) : '0;
                    n_st = S_DONE;
                end
            end
            S_SHIFT_RD: begin
                // open: move j-1 -> j while j > lo; remove: move j+1 -> j while j+1 < cnt
                if (r_open ? (r_j > r_lo) : (r_j + CW'(1) < r_cnt)) begin
                    raddr = r_open ? IW'(r_j - CW'(1)) : IW'(r_j + CW'(1));
                    n_st = S_SHIFT_WR;
                end else begin
                    n_st = S_FIN_RD;
                end
            end
            S_SHIFT_WR: begin
                we = 1'b1; waddr = r_j[IW-1:0];
                wstart = rstart; wlen = rlen; wused = rused;
                n_j = r_open ? r_j - CW'(1) : r_j + CW'(1);
                n_st = S_SHIFT_RD;
            end
            S_FIN_RD: begin
                n_st = S_FIN;
            end
            S_FIN: begin
                if (r_open) begin
                    // write the free remainder and the granted segment
                    we = 1'b1; waddr = IW'(r_pick + CW'(1));
                    wstart = r_pstart + r_size; wlen = r_plen - r_size; wused = 1'b0;
                    n_cnt = r_cnt + CW'(1);
                    n_plen = r_size; n_pused = 1'b1;
                    n_phase = PH_END; n_open = 1'b0;
                    n_nfp = IW'(r_pick + CW'(1));
                    n_st = S_FREE_PV;  // reuse as "write pick" step
                end else begin
                    n_cnt = r_cnt - CW'(1);
                    if (CW'(r_nfp) >= r_lo && r_nfp != '0) n_nfp = r_nfp - IW'(1);
                    if (CW'(n_nfp) >= n_cnt) n_nfp = '0;
                    if (r_phase == PH_NX) begin
                        if (r_pick != '0) begin
                            n_i = r_pick - CW'(1);
                            raddr = n_i[IW-1:0];
                            n_phase = PH_PV;
                            n_st = S_FREE_PV;
                        end else begin
                            n_ooff = r_ent_start; n_olen = r_acc; n_st = S_DONE;
                        end
                    end else begin
                        n_ooff = r_ent_start; n_olen = r_acc; n_st = S_DONE;
                    end
                end
            end
            S_FREE_NX: begin
                // entry pick+1 is on the read port
                if (r_i < r_cnt && !rused) begin
                    n_acc = r_acc + rlen;
                    we = 1'b1; waddr = r_pick[IW-1:0]; wstart = r_ent_start;
                    wlen = r_acc + rlen; wused = 1'b0;
                    n_open = 1'b0; n_lo = r_i; n_j = r_i; n_phase = PH_NX;
                    n_st = S_SHIFT_RD;
                end else if (r_pick != '0) begin
                    n_i = r_pick - CW'(1);
                    raddr = n_i[IW-1:0];
                    n_phase = PH_PV;
                    n_st = S_FREE_PV;
                end else begin
                    n_ooff = r_ent_start; n_olen = r_acc; n_st = S_DONE;
                end
            end
            S_FREE_PV: begin
                if (r_phase == PH_END) begin
                    // finish a split: mark granted segment
                    we = 1'b1; waddr = r_pick[IW-1:0]; wstart = r_pstart;
                    wlen = r_size; wused = 1'b1;
                    n_ost = ST_OK;
                    n_ooff = r_pstart; n_olen = r_size; n_st = S_DONE;
                end else if (r_phase == PH_PV) begin
                    n_phase = PH_SPLIT;  // wait for read data
                end else if (!rused) begin
                    // merge into previous entry, then remove pick
                    n_acc = rlen + r_acc; n_ent_start = rstart;
                    we = 1'b1; waddr = r_i[IW-1:0]; wstart = rstart;
                    wlen = rlen + r_acc; wused = 1'b0;
                    n_open = 1'b0; n_lo = r_pick; n_j = r_pick; n_phase = PH_PV;
                    n_pick = '0;
                    n_st = S_SHIFT_RD;
                end else begin
                    n_ooff = r_ent_start; n_olen = r_acc; n_st = S_DONE;
                end
                if (r_phase == PH_PV) raddr = r_i[IW-1:0];
            end
            S_DONE: begin
                if (!r_ov) begin
                    n_ov = 1'b1;
                    if (r_ost != ST_OK) begin
                        n_ooff = '0; n_olen = '0;
                    end
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
        // hold entry 0 at one free segment of the reset pool size
        if (!i_rst_n) begin
            we = 1'b1; waddr = '0; wstart = '0;
            wlen = AW'(POOL_RESET); wused = 1'b0;
        end
    end

    // after a remove that came from the previous-neighbor merge, r_phase is PH_PV
    // and r_pick is cleared, so S_FIN ends the request.

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != '0 && r_cnt <= MAXC) else $error("segment count out of range");
    a_nfp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_IDLE |-> CW'(r_nfp) < r_cnt) else $error("next-fit position past table");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("request taken while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_status)) else $error("result dropped");
endmodule
`default_nettype wire

// ----- sv/sfs_table.sv -----
// Segment table memory: start, length and used flag per entry.
// One write port and one registered read port; uses sfs_pkg.
`default_nettype none
module sfs_table #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 16,
    parameter int unsigned IW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire logic [AW-1:0] i_wstart,
    input  wire logic [AW-1:0] i_wlen,
    input  wire logic          i_wused,
    input  wire logic [IW-1:0] i_raddr,
    output logic      [AW-1:0] o_rstart,
    output logic      [AW-1:0] o_rlen,
    output logic               o_rused
);
    import sfs_pkg::*;
    logic [2*AW:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wused, i_wlen, i_wstart};
        end
        {o_rused, o_rlen, o_rstart} <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
